>>> rtl/mbdvrp_pkg.sv
// ----------------------------------------------------------------------------
// mbdvrp_pkg
// Shared types and constants for the M-Bus data record parser.
// ----------------------------------------------------------------------------
package mbdvrp_pkg;

  localparam logic [1:0] ST_RECORD = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;
  localparam logic [1:0] ST_BADDIF = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_UINT = 2'd1;
  localparam logic [1:0] KIND_DT   = 2'd2;
  localparam logic [1:0] KIND_RAW  = 2'd3;

  localparam logic [7:0] BYTE_FILL  = 8'h2F;
  localparam logic [7:0] BYTE_END0  = 8'h0F;
  localparam logic [7:0] BYTE_END1  = 8'h1F;
  localparam logic [7:0] VIF_DATE   = 8'h6C;
  localparam logic [7:0] VIF_DTIME  = 8'h6D;
  localparam logic [7:0] VIF_EXT    = 8'hFD;
  localparam logic [7:0] VIFE_STAT  = 8'h17;
  localparam logic [15:0] YEAR_BASE = 16'd2000;

  // Header step commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE, CMD_DIF, CMD_DIFE, CMD_VIF, CMD_VIFE, CMD_LEN, CMD_DATA
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       fix_len;  // load fixed length from DIF code
    logic       emit_rec; // emit record result built from current state
    logic       emit_end; // emit end result
    logic [1:0] end_st;
    logic       clr;      // clear payload state
  } ctl_t;

  typedef struct packed {
    logic [3:0] dif_code;
    logic [7:0] length;
    logic [7:0] byte_index;
    logic [7:0] rec_count;
  } sts_t;

  typedef struct packed {
    logic       last_result;
    logic [7:0] data_length;
    logic [63:0] value;
    logic [1:0] value_kind;
    logic [3:0] scale_exp;
    logic [3:0] quantity;
    logic [7:0] vif_byte;
    logic [1:0] function_field;
    logic [7:0] subunit;
    logic [7:0] tariff;
    logic [15:0] storage_number;
    logic [1:0] status;
  } res_t;

  // Fixed data length by DIF length code; 8'hFF bad, 8'hFE variable.
  function automatic logic [7:0] len_of(input logic [3:0] c);
    logic [7:0] l;
    unique case (c)
      4'h0: l = 8'd0;  4'h1: l = 8'd1;  4'h2: l = 8'd2;  4'h3: l = 8'd3;
      4'h4: l = 8'd4;  4'h5: l = 8'd4;  4'h6: l = 8'd6;  4'h7: l = 8'd8;
      4'h9: l = 8'd1;  4'hA: l = 8'd2;  4'hB: l = 8'd3;  4'hC: l = 8'd4;
      4'hD: l = 8'hFE;
      default: l = 8'hFF;
    endcase
    return l;
  endfunction

endpackage

>>> rtl/mbdvrp_ctrl.sv
// ----------------------------------------------------------------------------
// mbdvrp_ctrl
// Parse phase controller: walks DIF, DIFE, VIF, VIFE, length and data bytes.
// ----------------------------------------------------------------------------
module mbdvrp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic [7:0]         max_records,
  input  mbdvrp_pkg::sts_t   sts,
  output mbdvrp_pkg::ctl_t   ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFE, S_VIF, S_VIFE, S_LEN, S_DATA, S_SINK
  } state_t;

  state_t state_r, state_nxt;
  logic   stopped_r, stopped_nxt;
  logic [7:0] flen;

  assign flen = mbdvrp_pkg::len_of(sts.dif_code);

  // Next phase and datapath commands for one accepted byte.
  always_comb begin
    logic hdr_end;
    logic stop_now;
    hdr_end     = 1'b0;
    stop_now    = 1'b0;
    state_nxt   = state_r;
    stopped_nxt = stopped_r;
    ctl         = '0;
    ctl.cmd     = mbdvrp_pkg::CMD_NONE;
    if (step) begin
      unique case (state_r)
        S_IDLE: begin
          if (!stopped_r && data_byte != mbdvrp_pkg::BYTE_FILL) begin
            if (data_byte == mbdvrp_pkg::BYTE_END0 || data_byte == mbdvrp_pkg::BYTE_END1
                || sts.rec_count >= max_records) begin
              stop_now = 1'b1;
            end else begin
              ctl.cmd   = mbdvrp_pkg::CMD_DIF;
              state_nxt = data_byte[7] ? S_DIFE : S_VIF;
            end
          end
        end
        S_DIFE: begin
          ctl.cmd = mbdvrp_pkg::CMD_DIFE;
          if (!data_byte[7]) state_nxt = S_VIF;
        end
        S_VIF: begin
          ctl.cmd = mbdvrp_pkg::CMD_VIF;
          if (data_byte[7]) state_nxt = S_VIFE;
          else hdr_end = 1'b1;
        end
        S_VIFE: begin
          ctl.cmd = mbdvrp_pkg::CMD_VIFE;
          if (!data_byte[7]) hdr_end = 1'b1;
        end
        S_LEN: begin
          ctl.cmd = mbdvrp_pkg::CMD_LEN;
          if (data_byte == 8'd0) begin
            ctl.emit_rec = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_DATA;
          end
        end
        S_DATA: begin
          ctl.cmd = mbdvrp_pkg::CMD_DATA;
          if (sts.byte_index + 8'd1 >= sts.length) begin
            ctl.emit_rec = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
        default: ;
      endcase
      // End of header: fixed, variable or bad length code.
      if (hdr_end) begin
        if (flen == 8'hFF) begin
          ctl.emit_end = 1'b1;
          ctl.end_st   = mbdvrp_pkg::ST_BADDIF;
          state_nxt    = S_SINK;
        end else if (flen == 8'hFE) begin
          state_nxt = S_LEN;
        end else begin
          ctl.fix_len = 1'b1;
          if (flen == 8'd0) begin
            ctl.emit_rec = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      if (stop_now) stopped_nxt = 1'b1;
      // Final byte closes the payload.
      if (last_byte) begin
        if (state_nxt != S_SINK) begin
          ctl.emit_end = 1'b1;
          ctl.end_st   = (stopped_nxt || state_nxt == S_IDLE) ? mbdvrp_pkg::ST_DONE
                                                              : mbdvrp_pkg::ST_TRUNC;
        end
        ctl.clr     = 1'b1;
        state_nxt   = S_IDLE;
        stopped_nxt = 1'b0;
      end
    end
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      stopped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

>>> rtl/mbdvrp_dpath.sv
// ----------------------------------------------------------------------------
// mbdvrp_dpath
// Record accumulators and the result builder for the data record parser.
// ----------------------------------------------------------------------------
module mbdvrp_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         data_byte,
  input  mbdvrp_pkg::ctl_t   ctl,
  output mbdvrp_pkg::sts_t   sts,
  output mbdvrp_pkg::res_t   rec_res
);

  logic [7:0]  dif_r, vif_r, tariff_r, subunit_r, first_ext_r, len_r, bidx_r, cnt_r;
  logic [15:0] stor_r;
  logic [3:0]  ext_r;
  logic        has_ext_r, bcd_bad_r;
  logic [63:0] bin_r;
  logic [26:0] bcd_r, wgt_r;
  logic [26:0] w10, w100, lo_t, hi_t;

  assign sts.dif_code   = dif_r[3:0];
  assign sts.length     = len_r;
  assign sts.byte_index = bidx_r;
  assign sts.rec_count  = cnt_r;

  // BCD weights for the low and high nibble.
  assign w10  = 27'((wgt_r << 3) + (wgt_r << 1));
  assign w100 = 27'((w10 << 3) + (w10 << 1));
  assign lo_t = 27'(wgt_r * {23'd0, data_byte[3:0]});
  assign hi_t = 27'(w10 * {23'd0, data_byte[7:4]});

  // Accumulator updates.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      dif_r <= '0; vif_r <= '0; tariff_r <= '0; subunit_r <= '0; first_ext_r <= '0;
      len_r <= '0; bidx_r <= '0; cnt_r <= '0; stor_r <= '0; ext_r <= '0;
      has_ext_r <= 1'b0; bcd_bad_r <= 1'b0; bin_r <= '0; bcd_r <= '0; wgt_r <= 27'd1;
    end else begin
      if (ctl.emit_rec && cnt_r != 8'hFF) cnt_r <= cnt_r + 8'd1;
      unique case (ctl.cmd)
        mbdvrp_pkg::CMD_DIF: begin
          dif_r <= data_byte; vif_r <= '0; tariff_r <= '0; subunit_r <= '0;
          first_ext_r <= '0; len_r <= '0; bidx_r <= '0; ext_r <= '0;
          stor_r <= {15'd0, data_byte[6]};
          has_ext_r <= 1'b0; bcd_bad_r <= 1'b0; bin_r <= '0; bcd_r <= '0; wgt_r <= 27'd1;
        end
        mbdvrp_pkg::CMD_DIFE: begin
          if (ext_r < 4'd4) begin
            stor_r   <= stor_r | ({11'd0, data_byte[3:0], 1'b0} << {ext_r[1:0], 2'b00});
            tariff_r <= tariff_r | 8'({6'd0, data_byte[5:4]} << {ext_r[1:0], 1'b0});
          end
          if (ext_r < 4'd8) subunit_r <= subunit_r | 8'({7'd0, data_byte[6]} << ext_r[2:0]);
          if (ext_r != 4'd15) ext_r <= ext_r + 4'd1;
        end
        mbdvrp_pkg::CMD_VIF: begin
          vif_r <= data_byte;
          if (ctl.fix_len) len_r <= mbdvrp_pkg::len_of(dif_r[3:0]);
        end
        mbdvrp_pkg::CMD_VIFE: begin
          if (!has_ext_r) begin
            first_ext_r <= data_byte;
            has_ext_r   <= 1'b1;
          end
          if (ctl.fix_len) len_r <= mbdvrp_pkg::len_of(dif_r[3:0]);
        end
        mbdvrp_pkg::CMD_LEN: len_r <= data_byte;
        mbdvrp_pkg::CMD_DATA: begin
          if (bidx_r < 8'd8) bin_r <= bin_r | ({56'd0, data_byte} << {bidx_r[2:0], 3'b000});
          if (bidx_r < 8'd4) begin
            if (data_byte[3:0] > 4'd9 || data_byte[7:4] > 4'd9) bcd_bad_r <= 1'b1;
            bcd_r <= bcd_r + lo_t + hi_t;
            wgt_r <= w100;
          end
          bidx_r <= bidx_r + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // Record result built from the state as it stands after this byte.
  always_comb begin
    logic [7:0]  v, b0, b1, b2, b3, len, fe;
    logic [63:0] bin;
    logic [26:0] bcd;
    logic        bad, dn, he;
    logic [3:0]  q, code;
    logic [3:0]  s;
    logic [6:0]  y2, y4;
    v   = (ctl.cmd == mbdvrp_pkg::CMD_VIF) ? data_byte : vif_r;
    len = (ctl.cmd == mbdvrp_pkg::CMD_LEN) ? data_byte
        : ctl.fix_len ? mbdvrp_pkg::len_of(dif_r[3:0]) : len_r;
    // The first VIF extension counts even when it arrives with this byte.
    he  = has_ext_r;
    fe  = first_ext_r;
    if (ctl.cmd == mbdvrp_pkg::CMD_VIFE && !has_ext_r) begin
      he = 1'b1;
      fe = data_byte;
    end
    bin = bin_r;
    bcd = bcd_r;
    bad = bcd_bad_r;
    if (ctl.cmd == mbdvrp_pkg::CMD_DATA) begin
      if (bidx_r < 8'd8) bin = bin_r | ({56'd0, data_byte} << {bidx_r[2:0], 3'b000});
      if (bidx_r < 8'd4) begin
        bcd = bcd_r + lo_t + hi_t;
        if (data_byte[3:0] > 4'd9 || data_byte[7:4] > 4'd9) bad = 1'b1;
      end
    end
    code = dif_r[3:0];
    q = 4'd0; s = 4'd0;
    if (v[7:3] == 5'h02)      begin q = 4'd1; s = 4'({1'b0, v[2:0]} - 4'd6); end
    else if (v[7:3] == 5'h00) begin q = 4'd2; s = 4'({1'b0, v[2:0]} - 4'd3); end
    else if (v[7:3] == 5'h05) begin q = 4'd3; s = 4'({1'b0, v[2:0]} - 4'd3); end
    else if (v[7:3] == 5'h07) begin q = 4'd4; s = 4'({1'b0, v[2:0]} - 4'd6); end
    else if (v[7:2] == 6'h16) begin q = 4'd5; s = 4'({2'b0, v[1:0]} - 4'd3); end
    else if (v[7:2] == 6'h17) begin q = 4'd6; s = 4'({2'b0, v[1:0]} - 4'd3); end
    else if (v[7:2] == 6'h18) begin q = 4'd7; s = 4'({2'b0, v[1:0]} - 4'd3); end
    else if (v == mbdvrp_pkg::VIF_DATE)  q = 4'd8;
    else if (v == mbdvrp_pkg::VIF_DTIME) q = 4'd9;
    else if (v == mbdvrp_pkg::VIF_EXT && he && fe == mbdvrp_pkg::VIFE_STAT)
      q = 4'd10;
    b0 = bin[7:0]; b1 = bin[15:8]; b2 = bin[23:16]; b3 = bin[31:24];
    y2 = {b1[7:4], b0[7:5]};
    y4 = {b3[7:4], b2[7:5]};
    rec_res = '0;
    rec_res.status = mbdvrp_pkg::ST_RECORD;
    dn = 1'b0;
    if (len != 8'd0) begin
      if (q == 4'd8 && len == 8'd2) begin
        if (b0[4:0] != 0 && b1[3:0] != 0 && b1[3:0] <= 4'd12) begin
          dn = 1'b1;
          rec_res.value_kind = mbdvrp_pkg::KIND_DT;
          rec_res.value = {16'd0, mbdvrp_pkg::YEAR_BASE + {9'd0, y2},
                           4'd0, b1[3:0], 3'd0, b0[4:0], 16'd0};
        end
      end else if (q == 4'd9 && len == 8'd4) begin
        if (b0[5:0] <= 6'd59 && b1[4:0] <= 5'd23 && b2[4:0] != 0 && b3[3:0] != 0
            && b3[3:0] <= 4'd12) begin
          dn = 1'b1;
          rec_res.value_kind = mbdvrp_pkg::KIND_DT;
          rec_res.value = {15'd0, 1'b1, mbdvrp_pkg::YEAR_BASE + {9'd0, y4},
                           4'd0, b3[3:0], 3'd0, b2[4:0], 3'd0, b1[4:0], 2'd0, b0[5:0]};
        end
      end
      if (!dn) begin
        rec_res.value = bin;
        rec_res.value_kind = mbdvrp_pkg::KIND_RAW;
        if (q == 4'd10 || code == 4'hD) ;
        else if (code >= 4'h9 && code <= 4'hC) begin
          if (!bad) begin
            rec_res.value_kind = mbdvrp_pkg::KIND_UINT;
            rec_res.value = {37'd0, bcd};
          end
        end else if (code != 4'h5 && len <= 8'd8) begin
          rec_res.value_kind = mbdvrp_pkg::KIND_UINT;
        end
      end
    end
    rec_res.storage_number = stor_r;
    rec_res.tariff         = tariff_r;
    rec_res.subunit        = subunit_r;
    rec_res.function_field = dif_r[5:4];
    rec_res.vif_byte       = v;
    rec_res.quantity       = q;
    rec_res.scale_exp      = s;
    rec_res.data_length    = len;
    rec_res.last_result    = 1'b0;
  end

endmodule

>>> rtl/mbdvrp_outq.sv
// ----------------------------------------------------------------------------
// mbdvrp_outq
// Two-entry result queue feeding the output channel.
// ----------------------------------------------------------------------------
module mbdvrp_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_a,
  input  mbdvrp_pkg::res_t   res_a,
  input  logic               push_b,
  input  mbdvrp_pkg::res_t   res_b,
  output logic               empty,
  output logic               out_valid,
  output mbdvrp_pkg::res_t   out_res,
  input  logic               out_ready
);

  mbdvrp_pkg::res_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 2'd0;
  assign out_res   = q_r[0];
  assign empty     = cnt_r == 2'd0;

  // Shift out on pop, append pushes behind what remains.
  always_ff @(posedge clk) begin
    logic [1:0] k;
    k = cnt_r - {1'b0, pop};
    if (pop) q_r[0] <= q_r[1];
    if (push_a) begin
      q_r[k[0]] <= res_a;
      if (push_b) q_r[~k[0]] <= res_b;
    end else if (push_b) begin
      q_r[k[0]] <= res_b;
    end
  end

  always_comb cnt_nxt = cnt_r - {1'b0, pop} + {1'b0, push_a} + {1'b0, push_b};

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

endmodule

>>> rtl/mbus_dif_vif_record_parser_top.sv
// A record or end result is ready in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the result queue is empty; a byte that yields
// results blocks further input until its results (at most two) are taken.
// The two-entry result queue sets that figure.
// Reset (synchronous, active low) clears parse state; max_records returns to 255.
// ----------------------------------------------------------------------------
// mbus_dif_vif_record_parser_top
// M-Bus DIF/VIF data record parser with stream ports and an APB register.
// ----------------------------------------------------------------------------
module mbus_dif_vif_record_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [17:2] storage_number, [25:18] tariff, [33:26] subunit,
  // [35:34] function_field, [43:36] vif_byte, [47:44] quantity, [51:48] scale_exp,
  // [53:52] value_kind, [117:54] value, [125:118] data_length, [127:126] zero
  output logic [127:0] out_tdata,
  output logic        out_tlast,  // last_result
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mbdvrp_pkg::ctl_t ctl;
  mbdvrp_pkg::sts_t sts;
  mbdvrp_pkg::res_t rec_res, end_res, q_res;
  logic [7:0] max_rec_r;
  logic step, empty;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {24'd0, max_rec_r} : 32'd0;

  // Register write.
  always_ff @(posedge clk) begin
    if (!rst_n) max_rec_r <= 8'hFF;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      max_rec_r <= cfg_pwdata[7:0];
  end

  assign in_tready = empty;
  assign step      = in_tvalid && in_tready;

  mbdvrp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .step(step), .data_byte(in_tdata),
    .last_byte(in_tlast), .max_records(max_rec_r), .sts(sts), .ctl(ctl)
  );

  mbdvrp_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .data_byte(in_tdata), .ctl(ctl),
    .sts(sts), .rec_res(rec_res)
  );

  // End result: record count on done, counting a record finished by this byte.
  always_comb begin
    end_res = '0;
    end_res.status      = ctl.end_st;
    end_res.last_result = 1'b1;
    if (ctl.end_st == mbdvrp_pkg::ST_DONE)
      end_res.value = {56'd0, sts.rec_count +
                       {7'd0, ctl.emit_rec && sts.rec_count != 8'hFF}};
  end

  mbdvrp_outq u_outq (
    .clk(clk), .rst_n(rst_n),
    .push_a(ctl.emit_rec), .res_a(rec_res),
    .push_b(ctl.emit_end), .res_b(end_res),
    .empty(empty), .out_valid(out_tvalid), .out_res(q_res), .out_ready(out_tready)
  );

  assign out_tdata = {2'b00, q_res.data_length, q_res.value, q_res.value_kind,
                      q_res.scale_exp, q_res.quantity, q_res.vif_byte,
                      q_res.function_field, q_res.subunit, q_res.tariff,
                      q_res.storage_number, q_res.status};
  assign out_tlast = q_res.last_result;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the M-Bus DIF/VIF data record parser. Payloads of data
// records, fill bytes, end markers, truncations and noise are streamed in
// with random bursts and gaps, while the result side stalls on its own
// pattern. A behavioural parser predicts every record, done and error result,
// which is compared field by field with what the block returns. The record
// limit register is rewritten between phases, its extremes included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] REG_MAX_RECORDS = 2'd0;

  typedef enum logic [2:0] {
    P_IDLE, P_DIFE, P_VIF, P_VIFE, P_LEN, P_DATA, P_SINK
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] storage;
    logic [7:0]  tariff;
    logic [7:0]  subunit;
    logic [1:0]  func;
    logic [7:0]  vif;
    logic [3:0]  qty;
    logic [3:0]  scale;
    logic [1:0]  kind;
    logic [63:0] value;
    logic [7:0]  dlen;
    logic        last;
  } rec_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [1:0]   cfg_paddr = 2'd0;
  logic [31:0]  cfg_pwdata = 32'd0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  mbus_dif_vif_record_parser_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Pending payload bytes: bit 8 is the final-byte flag.
  logic [8:0]  pending_bytes[$];
  rec_result_t expected_results[$];
  int          mismatches = 0;
  int          bytes_queued = 0;

  // Parser state kept by the predictor.
  parse_phase_t ph;
  logic [7:0]  max_rec;
  logic [7:0]  dif_r, vif_r, vife_first, dlen_r, bidx, rec_cnt;
  logic [15:0] stor_acc;
  logic [7:0]  tar_acc, sub_acc;
  logic [3:0]  ext_idx;
  logic        has_vife, bcd_bad, stopped;
  logic [63:0] bin_acc;
  logic [26:0] bcd_acc, bcd_wt;

  function automatic logic [7:0] length_for_code(input logic [3:0] c);
    case (c)
      4'h0: return 8'd0;
      4'h1, 4'h9: return 8'd1;
      4'h2, 4'hA: return 8'd2;
      4'h3, 4'hB: return 8'd3;
      4'h4, 4'h5, 4'hC: return 8'd4;
      4'h6: return 8'd6;
      4'h7: return 8'd8;
      4'hD: return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  function void clear_record();
    dif_r = 0; vif_r = 0; stor_acc = 0; tar_acc = 0; sub_acc = 0; ext_idx = 0;
    vife_first = 0; has_vife = 0; dlen_r = 0; bidx = 0; bin_acc = 0; bcd_acc = 0;
    bcd_wt = 27'd1; bcd_bad = 0;
  endfunction

  function void clear_payload();
    clear_record();
    ph = P_IDLE;
    rec_cnt = 0;
    stopped = 0;
  endfunction

  function void push_end(input logic [1:0] st, input logic [63:0] val);
    rec_result_t r;
    r = '{status: st, storage: 0, tariff: 0, subunit: 0, func: 0, vif: 0, qty: 0,
          scale: 0, kind: mbdvrp_pkg::KIND_NONE, value: val, dlen: 0, last: 1'b1};
    expected_results.push_back(r);
  endfunction

  // Quantity and decimal exponent from the VIF byte.
  function void quantity_of(input logic [7:0] v, output logic [3:0] q, output int s);
    q = 0; s = 0;
    if ((v & 8'hF8) == 8'h10) begin q = 1; s = int'(v[2:0]) - 6; end
    else if ((v & 8'hF8) == 8'h00) begin q = 2; s = int'(v[2:0]) - 3; end
    else if ((v & 8'hF8) == 8'h28) begin q = 3; s = int'(v[2:0]) - 3; end
    else if ((v & 8'hF8) == 8'h38) begin q = 4; s = int'(v[2:0]) - 6; end
    else if ((v & 8'hFC) == 8'h58) begin q = 5; s = int'(v[1:0]) - 3; end
    else if ((v & 8'hFC) == 8'h5C) begin q = 6; s = int'(v[1:0]) - 3; end
    else if ((v & 8'hFC) == 8'h60) begin q = 7; s = int'(v[1:0]) - 3; end
    else if (v == mbdvrp_pkg::VIF_DATE) q = 8;
    else if (v == mbdvrp_pkg::VIF_DTIME) q = 9;
    else if (v == mbdvrp_pkg::VIF_EXT && has_vife && vife_first == mbdvrp_pkg::VIFE_STAT)
      q = 10;
  endfunction

  // Builds the record result from the current record state.
  function void emit_record();
    rec_result_t r;
    logic [3:0] q, code;
    int s;
    logic [7:0] b0, b1, b2, b3;
    logic [6:0] yr;
    logic done;
    b0 = bin_acc[7:0]; b1 = bin_acc[15:8]; b2 = bin_acc[23:16]; b3 = bin_acc[31:24];
    code = dif_r[3:0];
    done = 0;
    quantity_of(vif_r, q, s);
    r = '{status: mbdvrp_pkg::ST_RECORD, storage: stor_acc, tariff: tar_acc,
          subunit: sub_acc, func: dif_r[5:4], vif: vif_r, qty: q, scale: s[3:0],
          kind: mbdvrp_pkg::KIND_NONE, value: 0, dlen: dlen_r, last: 1'b0};
    if (dlen_r != 0) begin
      if (q == 8 && dlen_r == 2) begin
        yr = {b1[7:4], b0[7:5]};
        if (b0[4:0] != 0 && b1[3:0] != 0 && b1[3:0] <= 12) begin
          r.kind = mbdvrp_pkg::KIND_DT; done = 1;
          r.value = {15'd0, 1'b0, 16'(yr) + mbdvrp_pkg::YEAR_BASE, 4'd0, b1[3:0], 3'd0,
                     b0[4:0], 16'd0};
        end
      end else if (q == 9 && dlen_r == 4) begin
        yr = {b3[7:4], b2[7:5]};
        if (b0[5:0] <= 59 && b1[4:0] <= 23 && b2[4:0] != 0 && b3[3:0] != 0
            && b3[3:0] <= 12) begin
          r.kind = mbdvrp_pkg::KIND_DT; done = 1;
          r.value = {15'd0, 1'b1, 16'(yr) + mbdvrp_pkg::YEAR_BASE, 4'd0, b3[3:0], 3'd0,
                     b2[4:0], 3'd0, b1[4:0], 2'd0, b0[5:0]};
        end
      end
      if (!done) begin
        if (q == 10 || code == 4'hD) begin
          r.kind = mbdvrp_pkg::KIND_RAW; r.value = bin_acc;
        end else if (code >= 4'h9 && code <= 4'hC) begin
          if (bcd_bad) begin r.kind = mbdvrp_pkg::KIND_RAW; r.value = bin_acc; end
          else begin r.kind = mbdvrp_pkg::KIND_UINT; r.value = {37'd0, bcd_acc}; end
        end else if (code != 4'h5 && dlen_r <= 8) begin
          r.kind = mbdvrp_pkg::KIND_UINT; r.value = bin_acc;
        end else begin
          r.kind = mbdvrp_pkg::KIND_RAW; r.value = bin_acc;
        end
      end
    end
    expected_results.push_back(r);
    if (rec_cnt < 8'd255) rec_cnt++;
    ph = P_IDLE;
  endfunction

  function void end_header();
    logic [7:0] l;
    l = length_for_code(dif_r[3:0]);
    if (l == 8'hFF) begin
      push_end(mbdvrp_pkg::ST_BADDIF, 0);
      ph = P_SINK;
    end else if (l == 8'hFE) begin
      ph = P_LEN;
    end else begin
      dlen_r = l;
      if (l == 0) emit_record();
      else ph = P_DATA;
    end
  endfunction

  // Advances the parser by one accepted byte and queues the results it causes.
  function void parse_byte(input logic [7:0] b, input logic last);
    logic [31:0] ext;
    case (ph)
      P_IDLE: begin
        if (!stopped && b != mbdvrp_pkg::BYTE_FILL) begin
          if (b == mbdvrp_pkg::BYTE_END0 || b == mbdvrp_pkg::BYTE_END1
              || rec_cnt >= max_rec) begin
            stopped = 1;
          end else begin
            clear_record();
            dif_r = b;
            stor_acc = {15'd0, b[6]};
            ph = b[7] ? P_DIFE : P_VIF;
          end
        end
      end
      P_DIFE: begin
        if (ext_idx < 4) begin
          ext = {28'd0, b[3:0]} << (1 + 4 * ext_idx);
          stor_acc = stor_acc | ext[15:0];
          tar_acc = tar_acc | (8'(b[5:4]) << (2 * ext_idx));
        end
        if (ext_idx < 8) sub_acc = sub_acc | (8'(b[6]) << ext_idx);
        if (ext_idx < 15) ext_idx++;
        if (!b[7]) ph = P_VIF;
      end
      P_VIF: begin
        vif_r = b;
        if (b[7]) ph = P_VIFE;
        else end_header();
      end
      P_VIFE: begin
        if (!has_vife) begin vife_first = b; has_vife = 1; end
        if (!b[7]) end_header();
      end
      P_LEN: begin
        dlen_r = b;
        if (b == 0) emit_record();
        else ph = P_DATA;
      end
      P_DATA: begin
        if (bidx < 8) bin_acc = bin_acc | (64'(b) << (8 * bidx));
        if (bidx < 4) begin
          if (b[3:0] > 9 || b[7:4] > 9) bcd_bad = 1;
          bcd_acc = bcd_acc + 27'(b[3:0]) * bcd_wt;
          bcd_wt = bcd_wt * 27'd10;
          bcd_acc = bcd_acc + 27'(b[7:4]) * bcd_wt;
          bcd_wt = bcd_wt * 27'd10;
        end
        bidx++;
        if (bidx >= dlen_r) emit_record();
      end
      default: ;
    endcase
    if (last) begin
      if (ph == P_SINK) ;
      else if (stopped || ph == P_IDLE) push_end(mbdvrp_pkg::ST_DONE, {56'd0, rec_cnt});
      else push_end(mbdvrp_pkg::ST_TRUNC, 0);
      clear_payload();
    end
  endfunction

  // Byte driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast);
        void'(pending_bytes.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // Request still waiting: hold it.
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_bytes[0][7:0];
        in_tlast <= pending_bytes[0][8];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: picks a new random stall pattern whenever the low byte of its cycle counter wraps to zero.
  int unsigned rx_cycle = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle[7:0] == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= (rx_cycle[1:0] != 2'd0);
      2: out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= (rx_cycle[3:0] < 4'd3);
    endcase
  end

  // Result monitor: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    rec_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{status: out_tdata[1:0], storage: out_tdata[17:2], tariff: out_tdata[25:18],
              subunit: out_tdata[33:26], func: out_tdata[35:34], vif: out_tdata[43:36],
              qty: out_tdata[47:44], scale: out_tdata[51:48], kind: out_tdata[53:52],
              value: out_tdata[117:54], dlen: out_tdata[125:118], last: out_tlast};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got != want || out_tdata[127:126] != 2'b00) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch:\n  expected %p\n  actual   %p",
                                         want, got);
        end
      end
    end
  end

  function void queue_payload(input logic [7:0] bytes[$]);
    foreach (bytes[i]) pending_bytes.push_back({i == bytes.size() - 1, bytes[i]});
    bytes_queued += bytes.size();
  endfunction

  // Appends one record with random content; its DIF length code may be a bad one.
  function void add_record(inout logic [7:0] pl[$]);
    logic [3:0] code;
    logic [7:0] vif, l, b;
    int n;
    code = 4'($urandom_range(0, 15));
    if ((code == 4'h8 || code >= 4'hE) && $urandom_range(0, 3) != 0)
      code = $urandom_range(0, 7) == 0 ? 4'h5 : 4'($urandom_range(9, 13));
    case ($urandom_range(0, 7))
      0: begin vif = mbdvrp_pkg::VIF_DATE; if ($urandom_range(0, 2) != 0) code = 4'h2; end
      1: begin vif = mbdvrp_pkg::VIF_DTIME; if ($urandom_range(0, 2) != 0) code = 4'h4; end
      2: vif = mbdvrp_pkg::VIF_EXT;
      3: vif = 8'($urandom_range(0, 255));
      default: vif = {$urandom_range(0, 3) == 0, 7'($urandom_range(0, 127))};
    endcase
    n = ($urandom_range(0, 2) != 0) ? 0 :
        ($urandom_range(0, 7) == 0 ? $urandom_range(12, 18) : $urandom_range(1, 4));
    pl.push_back({n > 0, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), code});
    for (int i = 0; i < n; i++) pl.push_back({i < n - 1, 7'($urandom_range(0, 127))});
    pl.push_back(vif);
    if (vif[7]) begin
      if (vif == mbdvrp_pkg::VIF_EXT && $urandom_range(0, 1) == 1) begin
        pl.push_back(mbdvrp_pkg::VIFE_STAT);
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) pl.push_back({i < n - 1, 7'($urandom_range(0, 127))});
      end
    end
    l = length_for_code(code);
    if (l == 8'hFF) return;
    if (l == 8'hFE) begin
      l = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 30))
                                      : 8'($urandom_range(0, 9));
      pl.push_back(l);
    end
    for (int i = 0; i < l; i++) begin
      b = 8'($urandom_range(0, 255));
      if (code >= 4'h9 && code <= 4'hC && $urandom_range(0, 7) != 0)
        b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      else if ((vif == mbdvrp_pkg::VIF_DATE || vif == mbdvrp_pkg::VIF_DTIME)
               && $urandom_range(0, 1) == 1) begin
        if (vif == mbdvrp_pkg::VIF_DTIME && i == 0) b[5:0] = 6'($urandom_range(0, 59));
        if (vif == mbdvrp_pkg::VIF_DTIME && i == 1) b[4:0] = 5'($urandom_range(0, 23));
        if (i == l - 2) b[4:0] = 5'($urandom_range(1, 31));
        if (i == l - 1) b[3:0] = 4'($urandom_range(1, 12));
      end
      pl.push_back(b);
    end
  endfunction

  function void add_random_payload();
    logic [7:0] pl[$];
    int n;
    n = $urandom_range(0, 5);
    for (int r = 0; r < n; r++) begin
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) pl.push_back(mbdvrp_pkg::BYTE_FILL);
      add_record(pl);
    end
    case ($urandom_range(0, 9))
      0: begin
        pl.push_back($urandom_range(0, 1) ? mbdvrp_pkg::BYTE_END0 : mbdvrp_pkg::BYTE_END1);
        repeat ($urandom_range(0, 3)) pl.push_back(8'($urandom_range(0, 255)));
      end
      1: if (pl.size() > 1) repeat ($urandom_range(1, pl.size() - 1)) void'(pl.pop_back());
      2: pl.push_back(mbdvrp_pkg::BYTE_FILL);
      3: begin
        pl.delete();
        repeat ($urandom_range(1, 12)) pl.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    if (pl.size() == 0) pl.push_back(8'($urandom_range(0, 255)));
    queue_payload(pl);
  endfunction

  // Waits until every byte is taken and every result has come back.
  task automatic wait_idle();
    while (pending_bytes.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max_records(input logic [7:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= REG_MAX_RECORDS; cfg_pwdata <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    max_rec = val;
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      add_random_payload();
      while (pending_bytes.size() > 64) @(posedge clk);
    end
    wait_idle();
  endtask

  // Stimulus: directed payloads, then random phases under several limits.
  initial begin
    max_rec = 8'd255;
    clear_payload();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Fill, BCD record, end marker with trailing junk.
    queue_payload('{8'h2F, 8'h0C, 8'h13, 8'h78, 8'h56, 8'h34, 8'h12, 8'h0F, 8'h55});
    // Valid date and datetime records.
    queue_payload('{8'h02, mbdvrp_pkg::VIF_DATE, 8'h21, 8'h1C, 8'h04,
                    mbdvrp_pkg::VIF_DTIME, 8'h3B, 8'h17, 8'h21, 8'h1C});
    // Variable length of zero on a status VIF.
    queue_payload('{8'h0D, mbdvrp_pkg::VIF_EXT, mbdvrp_pkg::VIFE_STAT, 8'h00});
    // Bad length code, then a truncated record.
    queue_payload('{8'h08, 8'h13});
    queue_payload('{8'hFA, 8'hFF, 8'h13, 8'hFF});
    wait_idle();
    run_random(400);
    write_max_records(8'd0);
    run_random(150);
    write_max_records(8'd255);
    run_random(400);
    write_max_records(8'd1);
    run_random(250);
    write_max_records(8'd2);
    run_random(250);
    write_max_records(8'($urandom_range(3, 254)));
    run_random(200);
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
